FILE: rtl/core/counting_semaphore_table_unit_assert.svh
// Assertion macros for the semaphore table RTL.
`ifndef COUNTING_SEMAPHORE_TABLE_UNIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CSTU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("semaphore table: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CSTU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("semaphore table: next-cycle check failed");

`endif

FILE: rtl/core/csem_pkg.sv
// Shared types, codes and widths for the semaphore table.
package csem_pkg;

    // Fixed field widths of the channels
    localparam int CMD_W    = 3;
    localparam int SID_W    = 4;
    localparam int VAL_W    = 16;
    localparam int PIDIN_W  = 8;
    localparam int STAT_W   = 3;

    // Default configuration
    localparam int NUM_SEMS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int PID_BITS_DEF    = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WAIT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POST    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEC     = 3'd4;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE       = 3'd0,
        ST_BLOCKED    = 3'd1,
        ST_WOKEN      = 3'd2,
        ST_INVALID    = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_QUEUE_FULL = 3'd5
    } t_status;

    // One result item
    typedef struct packed {
        t_status              status;
        logic [SID_W-1:0]     slot;
        logic [PIDIN_W-1:0]   woken_pid;
        logic                 last;
    } t_result;

    // Write strobes toward the memories
    typedef struct packed {
        logic ctrl;
        logic waiter;
        logic freed;
    } t_mem_we;

endpackage

FILE: rtl/core/csem_mem.sv
// Semaphore control, waiter and freed-slot memories with registered reads.
module csem_mem import csem_pkg::*; #(
    parameter int NUM_SEMS    = NUM_SEMS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = PID_BITS_DEF,
    localparam int SLOT_W = $clog2(NUM_SEMS),
    localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW     = $clog2(QUEUE_DEPTH + 1),
    localparam int PW     = (PID_BITS < PIDIN_W) ? PID_BITS : PIDIN_W,
    localparam int CTRL_W = VAL_W + 2 * QW + CW
) (
    input  logic              i_clk,
    input  t_mem_we           i_we,
    input  logic [SLOT_W-1:0] i_ctrl_raddr,
    input  logic [SLOT_W-1:0] i_ctrl_waddr,
    input  logic [CTRL_W-1:0] i_ctrl_wdata,
    output logic [CTRL_W-1:0] o_ctrl_rdata,
    input  logic [SLOT_W-1:0] i_wt_rslot,
    input  logic [QW-1:0]     i_wt_ridx,
    input  logic [SLOT_W-1:0] i_wt_wslot,
    input  logic [QW-1:0]     i_wt_widx,
    input  logic [PW-1:0]     i_wt_wdata,
    output logic [PW-1:0]     o_wt_rdata,
    input  logic [SLOT_W-1:0] i_fr_raddr,
    input  logic [SLOT_W-1:0] i_fr_waddr,
    input  logic [SLOT_W-1:0] i_fr_wdata,
    output logic [SLOT_W-1:0] o_fr_rdata
);

    logic [CTRL_W-1:0] r_ctrl_mem [NUM_SEMS];
    logic [PW-1:0]     r_wt_mem   [NUM_SEMS][QUEUE_DEPTH];
    logic [SLOT_W-1:0] r_fr_mem   [NUM_SEMS];

    // Count and queue pointers per slot
    always_ff @(posedge i_clk) begin
        if (i_we.ctrl) begin
            r_ctrl_mem[i_ctrl_waddr] <= i_ctrl_wdata;
        end
        o_ctrl_rdata <= r_ctrl_mem[i_ctrl_raddr];
    end

    // Waiting process ids, one ring per slot
    always_ff @(posedge i_clk) begin
        if (i_we.waiter) begin
            r_wt_mem[i_wt_wslot][i_wt_widx] <= i_wt_wdata;
        end
        o_wt_rdata <= r_wt_mem[i_wt_rslot][i_wt_ridx];
    end

    // Stack of freed slots
    always_ff @(posedge i_clk) begin
        if (i_we.freed) begin
            r_fr_mem[i_fr_waddr] <= i_fr_wdata;
        end
        o_fr_rdata <= r_fr_mem[i_fr_raddr];
    end

endmodule

FILE: rtl/core/csem_seq.sv
// Command sequencer: read, modify and write back one slot per command.
module csem_seq import csem_pkg::*; #(
    parameter int NUM_SEMS    = NUM_SEMS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = PID_BITS_DEF,
    localparam int SLOT_W = $clog2(NUM_SEMS),
    localparam int NU_W   = $clog2(NUM_SEMS + 1),
    localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW     = $clog2(QUEUE_DEPTH + 1),
    localparam int PW     = (PID_BITS < PIDIN_W) ? PID_BITS : PIDIN_W,
    localparam int CTRL_W = VAL_W + 2 * QW + CW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [SID_W-1:0]   i_sem_id,
    input  logic [VAL_W-1:0]   i_initial_value,
    input  logic [PIDIN_W-1:0] i_pid,
    input  logic               i_out_free,
    output logic               o_busy,
    output logic               o_emit,
    output t_result            o_res,
    output t_mem_we            o_we,
    output logic [SLOT_W-1:0]  o_ctrl_raddr,
    output logic [SLOT_W-1:0]  o_ctrl_waddr,
    output logic [CTRL_W-1:0]  o_ctrl_wdata,
    input  logic [CTRL_W-1:0]  i_ctrl_rdata,
    output logic [SLOT_W-1:0]  o_wt_rslot,
    output logic [QW-1:0]      o_wt_ridx,
    output logic [QW-1:0]      o_wt_widx,
    output logic [PW-1:0]      o_wt_wdata,
    input  logic [PW-1:0]      i_wt_rdata,
    output logic [SLOT_W-1:0]  o_fr_raddr,
    output logic [SLOT_W-1:0]  o_fr_waddr,
    output logic [SLOT_W-1:0]  o_fr_wdata,
    input  logic [SLOT_W-1:0]  i_fr_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_DRAIN
    } t_state;

    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [SID_W-1:0]    r_sid, n_sid;
    logic [VAL_W-1:0]    r_init, n_init;
    logic [PW-1:0]       r_pid, n_pid;
    logic [SLOT_W-1:0]   r_s, n_s;
    logic [VAL_W-1:0]    r_cnt, n_cnt;
    logic [QW-1:0]       r_head, n_head;
    logic [QW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_rem, n_rem;
    logic [NUM_SEMS-1:0] r_live, n_live;
    logic [NU_W-1:0]     r_fc, n_fc;
    logic [NU_W-1:0]     r_nu, n_nu;

    logic [VAL_W-1:0]    rd_cnt;
    logic [QW-1:0]       rd_head;
    logic [QW-1:0]       rd_tail;
    logic [CW-1:0]       rd_qc;
    logic                sem_ok;
    logic [SLOT_W-1:0]   new_slot;

    // Advance a ring index with wrap
    function automatic logic [QW-1:0] q_inc(input logic [QW-1:0] idx);
        logic [QW-1:0] nxt;
        if (idx == QW'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + 1'b1;
        end
        return nxt;
    endfunction

    // Unpack the slot's control word
    assign rd_cnt  = i_ctrl_rdata[CTRL_W-1 -: VAL_W];
    assign rd_head = i_ctrl_rdata[2*QW+CW-1 -: QW];
    assign rd_tail = i_ctrl_rdata[QW+CW-1 -: QW];
    assign rd_qc   = i_ctrl_rdata[CW-1:0];

    assign sem_ok   = (32'(r_sid) < NUM_SEMS) && r_live[r_s];
    assign new_slot = (r_fc != '0) ? i_fr_rdata : SLOT_W'(r_nu);

    // Memory read addresses
    assign o_ctrl_raddr = (r_state == S_IDLE) ? SLOT_W'(i_sem_id) : r_s;
    assign o_fr_raddr   = (r_fc == '0) ? '0 : SLOT_W'(r_fc - 1'b1);
    assign o_wt_rslot   = r_s;
    assign o_wt_ridx    = n_head;
    assign o_busy       = (r_state != S_IDLE);

    // Decide the command and the write-back
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_sid   = r_sid;
        n_init  = r_init;
        n_pid   = r_pid;
        n_s     = r_s;
        n_cnt   = r_cnt;
        n_head  = r_head;
        n_tail  = r_tail;
        n_rem   = r_rem;
        n_live  = r_live;
        n_fc    = r_fc;
        n_nu    = r_nu;

        o_emit            = 1'b0;
        o_res.status      = ST_DONE;
        o_res.slot        = r_sid;
        o_res.woken_pid   = '0;
        o_res.last        = 1'b1;
        o_we              = '0;
        o_ctrl_waddr      = r_s;
        o_ctrl_wdata      = i_ctrl_rdata;
        o_wt_widx         = rd_tail;
        o_wt_wdata        = r_pid;
        o_fr_waddr        = SLOT_W'(r_fc);
        o_fr_wdata        = r_s;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_sid   = i_sem_id;
                    n_init  = i_initial_value;
                    n_pid   = PW'(i_pid);
                    n_s     = SLOT_W'(i_sem_id);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                    o_emit  = 1'b1;
                    if (r_cmd == CMD_CREATE) begin
                        if ((r_fc != '0) || (r_nu < NU_W'(NUM_SEMS))) begin
                            if (r_fc != '0) begin
                                n_fc = r_fc - 1'b1;
                            end else begin
                                n_nu = r_nu + 1'b1;
                            end
                            n_live[new_slot] = 1'b1;
                            o_we.ctrl        = 1'b1;
                            o_ctrl_waddr     = new_slot;
                            o_ctrl_wdata     = {r_init, {QW{1'b0}}, {QW{1'b0}}, {CW{1'b0}}};
                            o_res.slot       = SID_W'(new_slot);
                        end else begin
                            o_res.status = ST_TABLE_FULL;
                            o_res.slot   = '0;
                        end
                    end else if (!sem_ok) begin
                        o_res.status = ST_INVALID;
                    end else begin
                        case (r_cmd)
                            CMD_WAIT: begin
                                if (rd_cnt != '0) begin
                                    o_we.ctrl    = 1'b1;
                                    o_ctrl_wdata = {rd_cnt - 1'b1, rd_head, rd_tail, rd_qc};
                                end else if (rd_qc >= CW'(QUEUE_DEPTH)) begin
                                    o_res.status = ST_QUEUE_FULL;
                                end else begin
                                    o_we.waiter  = 1'b1;
                                    o_we.ctrl    = 1'b1;
                                    o_ctrl_wdata = {rd_cnt, rd_head, q_inc(rd_tail),
                                                    rd_qc + 1'b1};
                                    o_res.status = ST_BLOCKED;
                                end
                            end
                            CMD_POST: begin
                                if (rd_qc != '0) begin
                                    o_emit  = 1'b0;
                                    n_state = S_POP;
                                    n_head  = rd_head;
                                    n_cnt   = rd_cnt;
                                    n_tail  = rd_tail;
                                    n_rem   = rd_qc;
                                end else begin
                                    o_we.ctrl    = 1'b1;
                                    o_ctrl_wdata = {(rd_cnt != '1) ? rd_cnt + 1'b1 : rd_cnt,
                                                    rd_head, rd_tail, rd_qc};
                                end
                            end
                            CMD_DESTROY: begin
                                n_live[r_s] = 1'b0;
                                if (r_fc < NU_W'(NUM_SEMS)) begin
                                    o_we.freed = 1'b1;
                                    n_fc       = r_fc + 1'b1;
                                end
                                if (rd_qc != '0) begin
                                    o_emit  = 1'b0;
                                    n_state = S_DRAIN;
                                    n_head  = rd_head;
                                    n_rem   = rd_qc;
                                end
                            end
                            CMD_DEC: begin
                                if (rd_cnt != '0) begin
                                    o_we.ctrl    = 1'b1;
                                    o_ctrl_wdata = {rd_cnt - 1'b1, rd_head, rd_tail, rd_qc};
                                end
                            end
                            default: begin
                                o_res.status = ST_INVALID;
                            end
                        endcase
                    end
                end
            end
            S_POP: begin
                // Wake the oldest waiter and retire it from the ring
                if (i_out_free) begin
                    o_emit          = 1'b1;
                    o_res.status    = ST_WOKEN;
                    o_res.woken_pid = PIDIN_W'(i_wt_rdata);
                    o_we.ctrl       = 1'b1;
                    o_ctrl_wdata    = {r_cnt, q_inc(r_head), r_tail, r_rem - 1'b1};
                    n_state         = S_IDLE;
                end
            end
            S_DRAIN: begin
                // Release one waiter per transfer, oldest first
                if (i_out_free) begin
                    o_emit          = 1'b1;
                    o_res.status    = ST_WOKEN;
                    o_res.woken_pid = PIDIN_W'(i_wt_rdata);
                    o_res.last      = (r_rem == CW'(1));
                    n_head          = q_inc(r_head);
                    n_rem           = r_rem - 1'b1;
                    if (r_rem == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, allocation counters and the latched command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_fc    <= '0;
            r_nu    <= '0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_fc    <= n_fc;
            r_nu    <= n_nu;
        end
        r_cmd  <= n_cmd;
        r_sid  <= n_sid;
        r_init <= n_init;
        r_pid  <= n_pid;
        r_s    <= n_s;
        r_cnt  <= n_cnt;
        r_head <= n_head;
        r_tail <= n_tail;
        r_rem  <= n_rem;
    end

endmodule

FILE: rtl/core/counting_semaphore_table_unit.sv
// Top level of the counting semaphore table with per-slot FIFO wait queues.
//
// Input channel: i_valid / o_stall carry one command (create, wait, post,
// destroy, kernel decrement) per transfer. Output channel: o_valid / i_stall
// carry result items; o_last marks the final result of a command.
// A command is taken only while the sequencer is idle. Each command reads its
// slot's control word from memory in the transfer cycle and writes any change
// back in its decision step once the output register is free; a post that
// wakes a waiter instead writes it back in an extra wake step, which reads the
// waiter memory, and a destroy with waiters adds a drain step that releases
// one waiter per result.
// Results sit in an output register, so the next command is taken while the
// last result still waits; a stalled receiver holds the sequencer in its
// decision, wake or drain step until the register frees.
// Reset clears the live bits, the freed-slot count and the next-unused count
// at once; the memories need no clearing pass.
`include "counting_semaphore_table_unit_assert.svh"

module counting_semaphore_table_unit import csem_pkg::*; #(
    parameter int NUM_SEMS    = NUM_SEMS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = PID_BITS_DEF,
    localparam int SLOT_W = $clog2(NUM_SEMS),
    localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW     = $clog2(QUEUE_DEPTH + 1),
    localparam int PW     = (PID_BITS < PIDIN_W) ? PID_BITS : PIDIN_W,
    localparam int CTRL_W = VAL_W + 2 * QW + CW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [SID_W-1:0]   i_sem_id,
    input  logic [VAL_W-1:0]   i_initial_value,
    input  logic [PIDIN_W-1:0] i_pid,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [SID_W-1:0]   o_slot,
    output logic [PIDIN_W-1:0] o_woken_pid,
    output logic               o_last
);

    logic              busy;
    logic              emit;
    logic              out_free;
    t_result           res;
    t_mem_we           mem_we;
    logic [SLOT_W-1:0] ctrl_raddr, ctrl_waddr;
    logic [CTRL_W-1:0] ctrl_wdata, ctrl_rdata;
    logic [SLOT_W-1:0] wt_rslot;
    logic [QW-1:0]     wt_ridx, wt_widx;
    logic [PW-1:0]     wt_wdata, wt_rdata;
    logic [SLOT_W-1:0] fr_raddr, fr_waddr, fr_wdata, fr_rdata;

    logic              r_out_valid;
    t_result           r_out;

    csem_seq #(
        .NUM_SEMS    (NUM_SEMS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_BITS    (PID_BITS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_cmd           (i_cmd),
        .i_sem_id        (i_sem_id),
        .i_initial_value (i_initial_value),
        .i_pid           (i_pid),
        .i_out_free      (out_free),
        .o_busy          (busy),
        .o_emit          (emit),
        .o_res           (res),
        .o_we            (mem_we),
        .o_ctrl_raddr    (ctrl_raddr),
        .o_ctrl_waddr    (ctrl_waddr),
        .o_ctrl_wdata    (ctrl_wdata),
        .i_ctrl_rdata    (ctrl_rdata),
        .o_wt_rslot      (wt_rslot),
        .o_wt_ridx       (wt_ridx),
        .o_wt_widx       (wt_widx),
        .o_wt_wdata      (wt_wdata),
        .i_wt_rdata      (wt_rdata),
        .o_fr_raddr      (fr_raddr),
        .o_fr_waddr      (fr_waddr),
        .o_fr_wdata      (fr_wdata),
        .i_fr_rdata      (fr_rdata)
    );

    csem_mem #(
        .NUM_SEMS    (NUM_SEMS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_BITS    (PID_BITS)
    ) u_mem (
        .i_clk        (i_clk),
        .i_we         (mem_we),
        .i_ctrl_raddr (ctrl_raddr),
        .i_ctrl_waddr (ctrl_waddr),
        .i_ctrl_wdata (ctrl_wdata),
        .o_ctrl_rdata (ctrl_rdata),
        .i_wt_rslot   (wt_rslot),
        .i_wt_ridx    (wt_ridx),
        .i_wt_wslot   (wt_rslot),
        .i_wt_widx    (wt_widx),
        .i_wt_wdata   (wt_wdata),
        .o_wt_rdata   (wt_rdata),
        .i_fr_raddr   (fr_raddr),
        .i_fr_waddr   (fr_waddr),
        .i_fr_wdata   (fr_wdata),
        .o_fr_rdata   (fr_rdata)
    );

    // Output register is free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = busy;

    // Load a new result or drop the one just transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out.status;
    assign o_slot      = r_out.slot;
    assign o_woken_pid = r_out.woken_pid;
    assign o_last      = r_out.last;

    // A result is produced only into a free output register
    `CSTU_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, emit, out_free)
    // An accepted command keeps the sequencer busy in the next cycle
    `CSTU_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, busy)
    // A result that is not the last leaves the sequencer still draining
    `CSTU_ASSERT_NXT(a_more_busy, i_clk, i_rst_n, emit && !res.last, busy)

endmodule

FILE: bench/csem_checker.sv
// Result checker for the semaphore table: predicts each command's results and compares them.
`timescale 1ns / 100ps

module csem_checker import csem_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  logic               i_cmd_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [SID_W-1:0]   i_sem_id,
    input  logic [VAL_W-1:0]   i_initial_value,
    input  logic [PIDIN_W-1:0] i_pid,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic [STAT_W-1:0]  i_status,
    input  logic [SID_W-1:0]   i_slot,
    input  logic [PIDIN_W-1:0] i_woken_pid,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int SEMS   = NUM_SEMS_DEF;
    localparam int DEPTH  = QUEUE_DEPTH_DEF;
    localparam int QPTR_W = $clog2(DEPTH);
    localparam int QLEN_W = $clog2(DEPTH + 1);

    // Shadow copy of the semaphore table
    logic [VAL_W-1:0]   sem_count  [SEMS];
    logic               sem_live   [SEMS];
    logic [PIDIN_W-1:0] waiter_pid [SEMS][DEPTH];
    logic [QPTR_W-1:0]  wq_head    [SEMS];
    logic [QPTR_W-1:0]  wq_tail    [SEMS];
    logic [QLEN_W-1:0]  wq_len     [SEMS];
    logic [SID_W-1:0]   freed_slot [SEMS];
    logic [SID_W:0]     freed_depth;
    logic [SID_W:0]     fresh_next;

    t_result results_due [$];
    int      mismatches = 0;

    task automatic queue_result(input t_status st, input logic [SID_W-1:0] sl,
                                input logic [PIDIN_W-1:0] wp, input logic lst);
        t_result r;
        r.status    = st;
        r.slot      = sl;
        r.woken_pid = wp;
        r.last      = lst;
        results_due.push_back(r);
    endtask

    // Take the oldest waiter off a slot's queue
    task automatic pop_waiter(input logic [SID_W-1:0] sid, output logic [PIDIN_W-1:0] p);
        p            = waiter_pid[sid][wq_head[sid]];
        wq_head[sid] = wq_head[sid] + 1'b1;
        wq_len[sid]  = wq_len[sid] - 1'b1;
    endtask

    // Advance the shadow table by one command and queue the results it causes
    task automatic apply_command(input logic [CMD_W-1:0] c, input logic [SID_W-1:0] sid,
                                 input logic [VAL_W-1:0] v, input logic [PIDIN_W-1:0] p);
        logic [SID_W-1:0]   fresh;
        logic [PIDIN_W-1:0] popped;
        logic               got_slot;
        got_slot = 1'b1;
        fresh    = '0;
        if (c == CMD_CREATE) begin
            // Reuse the most recently freed slot, else the next never-used one
            if (freed_depth != 0) begin
                freed_depth = freed_depth - 1'b1;
                fresh       = freed_slot[freed_depth[SID_W-1:0]];
            end else if (fresh_next < SEMS) begin
                fresh      = fresh_next[SID_W-1:0];
                fresh_next = fresh_next + 1'b1;
            end else begin
                got_slot = 1'b0;
            end
            if (got_slot) begin
                sem_live[fresh]  = 1'b1;
                sem_count[fresh] = v;
                wq_head[fresh]   = '0;
                wq_tail[fresh]   = '0;
                wq_len[fresh]    = '0;
                queue_result(ST_DONE, fresh, '0, 1'b1);
            end else begin
                queue_result(ST_TABLE_FULL, '0, '0, 1'b1);
            end
        end else if (c > CMD_DEC || !sem_live[sid]) begin
            queue_result(ST_INVALID, sid, '0, 1'b1);
        end else begin
            case (c)
                CMD_WAIT: begin
                    if (sem_count[sid] != 0) begin
                        sem_count[sid] = sem_count[sid] - 1'b1;
                        queue_result(ST_DONE, sid, '0, 1'b1);
                    end else if (wq_len[sid] >= DEPTH) begin
                        queue_result(ST_QUEUE_FULL, sid, '0, 1'b1);
                    end else begin
                        // PID_BITS covers the whole pid field, so keep it all
                        waiter_pid[sid][wq_tail[sid]] = p;
                        wq_tail[sid] = wq_tail[sid] + 1'b1;
                        wq_len[sid]  = wq_len[sid] + 1'b1;
                        queue_result(ST_BLOCKED, sid, '0, 1'b1);
                    end
                end
                CMD_POST: begin
                    if (wq_len[sid] != 0) begin
                        pop_waiter(sid, popped);
                        queue_result(ST_WOKEN, sid, popped, 1'b1);
                    end else begin
                        // Saturate at the top of the count range
                        if (sem_count[sid] != {VAL_W{1'b1}})
                            sem_count[sid] = sem_count[sid] + 1'b1;
                        queue_result(ST_DONE, sid, '0, 1'b1);
                    end
                end
                CMD_DESTROY: begin
                    if (wq_len[sid] == 0) begin
                        queue_result(ST_DONE, sid, '0, 1'b1);
                    end else begin
                        while (wq_len[sid] != 0) begin
                            pop_waiter(sid, popped);
                            queue_result(ST_WOKEN, sid, popped, wq_len[sid] == 0);
                        end
                    end
                    sem_live[sid] = 1'b0;
                    if (freed_depth < SEMS) begin
                        freed_slot[freed_depth[SID_W-1:0]] = sid;
                        freed_depth = freed_depth + 1'b1;
                    end
                end
                default: begin
                    // Kernel decrement: floor at zero, never queue
                    if (sem_count[sid] != 0)
                        sem_count[sid] = sem_count[sid] - 1'b1;
                    queue_result(ST_DONE, sid, '0, 1'b1);
                end
            endcase
        end
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic check_result();
        t_result want;
        if (results_due.size() == 0) begin
            $error("unexpected result: status %0d slot %0d woken_pid %0d last %0d",
                   i_status, i_slot, i_woken_pid, i_last);
            mismatches++;
        end else begin
            want = results_due.pop_front();
            if (i_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, i_status);
                mismatches++;
            end
            if (i_slot !== want.slot) begin
                $error("slot: expected %0d, got %0d", want.slot, i_slot);
                mismatches++;
            end
            if (i_woken_pid !== want.woken_pid) begin
                $error("woken_pid: expected %0d, got %0d", want.woken_pid, i_woken_pid);
                mismatches++;
            end
            if (i_last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, i_last);
                mismatches++;
            end
        end
    endtask

    // Watch both channels on every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SEMS; k++)
                sem_live[k] = 1'b0;
            freed_depth = '0;
            fresh_next  = '0;
            results_due.delete();
        end else begin
            if (i_cmd_valid && !i_cmd_stall)
                apply_command(i_cmd, i_sem_id, i_initial_value, i_pid);
            if (i_res_valid && !i_res_stall)
                check_result();
        end
        o_fail_count <= mismatches;
        o_pending    <= results_due.size();
    end

endmodule

FILE: bench/tb_top.sv
// Testbench top for the semaphore table: drives commands and result stalls, gives the verdict.
`timescale 1ns / 100ps

module tb_top;
    import csem_pkg::*;

    localparam int RANDOM_ITEMS = 346;
    localparam int LIMIT_CYCLES = 200000;
    localparam int IDLE_PCT     = 38;

    // Command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    logic [CMD_W-1:0]   cmd = CMD_CREATE;
    logic [SID_W-1:0]   sem_id = '0;
    logic [VAL_W-1:0]   init_value = '0;
    logic [PIDIN_W-1:0] pid = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic [STAT_W-1:0]  res_status;
    logic [SID_W-1:0]   res_slot;
    logic [PIDIN_W-1:0] res_woken;
    logic               res_last;

    int fail_count;
    int pending;
    int items_sent = 0;
    int cycle_count = 0;
    bit quiet = 1'b0;

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    counting_semaphore_table_unit DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (cmd_valid),
        .o_stall        (cmd_stall),
        .i_cmd          (cmd),
        .i_sem_id       (sem_id),
        .i_initial_value(init_value),
        .i_pid          (pid),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_status       (res_status),
        .o_slot         (res_slot),
        .o_woken_pid    (res_woken),
        .o_last         (res_last)
    );

    csem_checker results_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd_stall    (cmd_stall),
        .i_cmd          (cmd),
        .i_sem_id       (sem_id),
        .i_initial_value(init_value),
        .i_pid          (pid),
        .i_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .i_status       (res_status),
        .i_slot         (res_slot),
        .i_woken_pid    (res_woken),
        .i_last         (res_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Stall the result side at random, except in the quiet stretch
    always @(posedge clk) begin
        res_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Drop the run if it hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Drive one command and hold it until the transfer
    task automatic issue(input logic [CMD_W-1:0] c, input logic [SID_W-1:0] s,
                         input logic [VAL_W-1:0] v, input logic [PIDIN_W-1:0] p);
        if (!quiet) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                cmd_valid <= 1'b0;
                @(posedge clk);
            end
        end
        cmd_valid  <= 1'b1;
        cmd        <= c;
        sem_id     <= s;
        init_value <= v;
        pid        <= p;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Random field values at the field widths
    function automatic logic [VAL_W-1:0] rnd_val();
        return VAL_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [PIDIN_W-1:0] rnd_pid();
        return PIDIN_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [SID_W-1:0] rnd_sid(input int hi);
        return SID_W'($urandom_range(0, hi));
    endfunction

    // Mostly small counts so that waits block; sometimes the extremes
    function automatic logic [VAL_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return '0;
        else if (r < 75)
            return VAL_W'($urandom_range(1, 3));
        else if (r < 90)
            return rnd_val();
        else
            return VAL_W'({VAL_W{1'b1}} - $urandom_range(0, 1));
    endfunction

    initial begin
        int                 kind;
        int                 random_end;
        logic [SID_W-1:0]   s;
        logic [CMD_W-1:0]   c;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: invalid slots and codes, saturation, full queue, draining destroy
        issue(CMD_WAIT, 4'd15, 16'hffff, 8'hff);
        issue(CMD_UNUSED_7, 4'd9, '0, '0);
        issue(CMD_CREATE, '0, 16'hffff, '0);
        issue(CMD_POST, 4'd0, '0, '0);
        issue(CMD_DEC, 4'd0, '0, '0);
        issue(CMD_CREATE, 4'd15, 16'h0000, 8'hff);
        issue(CMD_DEC, 4'd1, '0, '0);
        issue(CMD_WAIT, 4'd1, '0, 8'h00);
        issue(CMD_WAIT, 4'd1, '0, 8'hff);
        repeat (6)
            issue(CMD_WAIT, 4'd1, rnd_val(), rnd_pid());
        issue(CMD_WAIT, 4'd1, '0, 8'h5a);
        issue(CMD_POST, 4'd1, '0, '0);
        issue(CMD_DESTROY, 4'd1, '0, '0);
        issue(CMD_DESTROY, 4'd0, '0, '0);
        issue(CMD_CREATE, '0, 16'h1234, '0);
        issue(CMD_UNUSED_5, 4'd3, '0, '0);
        issue(CMD_UNUSED_6, 4'd0, '0, '0);
        issue(CMD_POST, 4'd1, '0, '0);

        // Random: episodes of related commands on a few slots, with some noise
        random_end = items_sent + RANDOM_ITEMS;
        while (items_sent < random_end) begin
            quiet = (items_sent >= 200 && items_sent < 280);
            kind  = $urandom_range(0, 99);
            s     = ($urandom_range(0, 3) == 0) ? rnd_sid(15) : rnd_sid(5);
            if (kind < 15) begin
                repeat ($urandom_range(1, 3))
                    issue(CMD_CREATE, rnd_sid(15), pick_count(), rnd_pid());
            end else if (kind < 35) begin
                repeat ($urandom_range(1, 10))
                    issue(CMD_WAIT, s, rnd_val(), rnd_pid());
            end else if (kind < 50) begin
                repeat ($urandom_range(1, 4))
                    issue(CMD_POST, s, rnd_val(), rnd_pid());
            end else if (kind < 70) begin
                repeat ($urandom_range(2, 8)) begin
                    case ($urandom_range(0, 2))
                        0:       c = CMD_WAIT;
                        1:       c = CMD_POST;
                        default: c = CMD_DEC;
                    endcase
                    issue(c, s, rnd_val(), rnd_pid());
                end
            end else if (kind < 80) begin
                issue(CMD_DESTROY, s, rnd_val(), rnd_pid());
            end else if (kind < 83) begin
                // Fill the table past its end
                repeat (17)
                    issue(CMD_CREATE, rnd_sid(15), pick_count(), rnd_pid());
            end else if (kind < 88) begin
                repeat ($urandom_range(3, 8))
                    issue(CMD_DESTROY, rnd_sid(15), rnd_val(), rnd_pid());
            end else begin
                repeat ($urandom_range(1, 3))
                    issue(CMD_W'($urandom_range(0, 7)), rnd_sid(15), rnd_val(), rnd_pid());
            end
        end
        quiet = 1'b0;
        cmd_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/csem_pkg.sv
rtl/core/csem_mem.sv
rtl/core/csem_seq.sv
rtl/core/counting_semaphore_table_unit.sv
bench/csem_checker.sv
bench/tb_top.sv
